// File: hw/rtl/gpd_pkg.sv
// Shared constants and types for the grid local peak detector.
`timescale 1ns / 1ps

package gpd_pkg;

  localparam int MAX_ROWS     = 1024;
  localparam int MAX_COLS     = 1024;
  localparam int SAMPLE_WIDTH = 16;

  localparam int ROW_W      = $clog2(MAX_ROWS);
  localparam int COL_W      = $clog2(MAX_COLS);
  localparam int CFG_W      = 11;
  localparam int CFG_ADDR_W = 3;
  localparam int CFG_DATA_W = 32;
  localparam int ENTRY_W    = 2 * SAMPLE_WIDTH;

  localparam int ROWS_RST_LAST = ((MAX_ROWS < 1024) ? MAX_ROWS : 1024) - 1;
  localparam int COLS_RST_LAST = ((MAX_COLS < 1024) ? MAX_COLS : 1024) - 1;

  localparam int QDEPTH = 4;
  localparam int QPTR_W = $clog2(QDEPTH);
  localparam int QLVL_W = $clog2(QDEPTH + 1);

  localparam logic [0:0] REG_NUM_ROWS = 1'b0;
  localparam logic [0:0] REG_NUM_COLS = 1'b1;

  // result kinds within one bundle, in output order
  localparam int RES_UP     = 0;  // cell above the sample
  localparam int RES_LEFT   = 1;  // last row, cell left of the sample
  localparam int RES_CORNER = 2;  // last cell of the grid

  typedef logic signed [SAMPLE_WIDTH-1:0] sample_t;

  typedef struct packed {
    logic [ROW_W-1:0] rows_last;
    logic [COL_W-1:0] cols_last;
  } cfg_dims_t;

  typedef struct packed {
    logic [ROW_W-1:0] row;
    logic [COL_W-1:0] col;
    logic [2:0]       has;
    logic [2:0]       peak;
  } bundle_t;

endpackage

// File: hw/rtl/gpd_ram.sv
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps

module gpd_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// File: hw/rtl/gpd_front.sv
// Front end: accepts samples, keeps the row store and window, classifies decisions.
`timescale 1ns / 1ps

module gpd_front (
  input  logic                           clk,
  input  logic                           rst_n,
  input  gpd_pkg::cfg_dims_t             dims,
  input  logic                           restart,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  gpd_pkg::sample_t               in_pixel_value,
  input  logic [gpd_pkg::QLVL_W-1:0]     q_level,
  output logic                           q_push,
  output gpd_pkg::bundle_t               q_bundle
);

  import gpd_pkg::*;

  logic               in_acc;
  logic [ROW_W-1:0]   row_r, row_nxt;
  logic [COL_W-1:0]   col_r, col_nxt;
  logic [COL_W-1:0]   rd_addr;
  logic [ENTRY_W-1:0] rd_data;
  logic [ENTRY_W-1:0] wr_data;
  sample_t            cur_m, cur_u, right_m;
  sample_t            x1_r, x2_r, mprev_r;
  logic               s1_valid_r;

  logic [ROW_W-1:0]   s1_row_r;
  logic [COL_W-1:0]   s1_col_r;
  sample_t            s1_x_r, s1_m_r, s1_u_r, s1_ml_r, s1_xl_r, s1_xll_r;
  logic               s1_r1_r, s1_r2_r, s1_c1_r, s1_c2_r, s1_hr_r, s1_lrow_r, s1_lcol_r;
  logic [2:0]         has, peak;

  assign in_stall = ((QLVL_W + 1)'(q_level) + (QLVL_W + 1)'(s1_valid_r))
                    >= (QLVL_W + 1)'(QDEPTH);
  assign in_acc   = in_valid & ~in_stall;

  // store entry per column: {row above sample, two rows above}
  assign cur_m   = sample_t'(rd_data[ENTRY_W-1 -: SAMPLE_WIDTH]);
  assign cur_u   = sample_t'(rd_data[SAMPLE_WIDTH-1:0]);
  assign right_m = cur_m;
  assign wr_data = {in_pixel_value, cur_m};
  assign rd_addr = (col_r == dims.cols_last) ? '0 : col_r + COL_W'(1);

  gpd_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (MAX_COLS)
  ) u_rows (
    .clk   (clk),
    .we    (in_acc),
    .waddr (col_r),
    .wdata (wr_data),
    .re    (in_acc),
    .raddr (rd_addr),
    .rdata (rd_data)
  );

  always_comb begin
    row_nxt = row_r;
    col_nxt = col_r;
    if (restart) begin
      row_nxt = '0;
      col_nxt = '0;
    end else if (in_acc) begin
      if (col_r == dims.cols_last) begin
        col_nxt = '0;
        row_nxt = (row_r == dims.rows_last) ? '0 : row_r + ROW_W'(1);
      end else begin
        col_nxt = col_r + COL_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_r      <= '0;
      col_r      <= '0;
      s1_valid_r <= 1'b0;
    end else begin
      row_r      <= row_nxt;
      col_r      <= col_nxt;
      s1_valid_r <= in_acc;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      x1_r      <= in_pixel_value;
      x2_r      <= x1_r;
      mprev_r   <= cur_m;
      s1_row_r  <= row_r;
      s1_col_r  <= col_r;
      s1_x_r    <= in_pixel_value;
      s1_m_r    <= cur_m;
      s1_u_r    <= cur_u;
      s1_ml_r   <= mprev_r;
      s1_xl_r   <= x1_r;
      s1_xll_r  <= x2_r;
      s1_r1_r   <= (row_r != '0);
      s1_r2_r   <= (row_r[ROW_W-1:1] != '0);
      s1_c1_r   <= (col_r != '0);
      s1_c2_r   <= (col_r[COL_W-1:1] != '0);
      s1_hr_r   <= (col_r != dims.cols_last);
      s1_lrow_r <= (row_r == dims.rows_last);
      s1_lcol_r <= (col_r == dims.cols_last);
    end
  end

  // right neighbor of the cell above arrives from the look-ahead read
  always_comb begin
    has              = '0;
    has[RES_UP]      = s1_r1_r;
    has[RES_LEFT]    = s1_lrow_r & s1_c1_r;
    has[RES_CORNER]  = s1_lrow_r & s1_lcol_r;
    peak             = '0;
    peak[RES_UP]     = (s1_m_r >= s1_x_r)
                     & (~s1_r2_r | (s1_m_r >= s1_u_r))
                     & (~s1_c1_r | (s1_m_r >= s1_ml_r))
                     & (~s1_hr_r | (s1_m_r >= right_m));
    peak[RES_LEFT]   = (s1_xl_r >= s1_x_r) & (s1_xl_r >= s1_ml_r)
                     & (~s1_c2_r | (s1_xl_r >= s1_xll_r));
    peak[RES_CORNER] = (s1_x_r >= s1_xl_r) & (s1_x_r >= s1_m_r);
  end

  assign q_push        = s1_valid_r & (has != '0);
  assign q_bundle.row  = s1_row_r;
  assign q_bundle.col  = s1_col_r;
  assign q_bundle.has  = has;
  assign q_bundle.peak = peak;

endmodule

// File: hw/rtl/gpd_queue.sv
// Short bundle queue between the front and back ends.
`timescale 1ns / 1ps

module gpd_queue (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       push,
  input  gpd_pkg::bundle_t           din,
  input  logic                       pop,
  output gpd_pkg::bundle_t           dout,
  output logic                       q_valid,
  output logic [gpd_pkg::QLVL_W-1:0] level
);

  import gpd_pkg::*;

  bundle_t           mem_r [QDEPTH];
  logic [QPTR_W-1:0] wp_r, rp_r;
  logic [QLVL_W-1:0] lvl_r;

  assign dout    = mem_r[rp_r];
  assign q_valid = (lvl_r != '0);
  assign level   = lvl_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      lvl_r <= '0;
    end else begin
      if (push) begin
        wp_r <= (wp_r == QPTR_W'(QDEPTH - 1)) ? '0 : wp_r + QPTR_W'(1);
      end
      if (pop) begin
        rp_r <= (rp_r == QPTR_W'(QDEPTH - 1)) ? '0 : rp_r + QPTR_W'(1);
      end
      if (push && !pop) begin
        lvl_r <= lvl_r + QLVL_W'(1);
      end else if (pop && !push) begin
        lvl_r <= lvl_r - QLVL_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wp_r] <= din;
    end
  end

endmodule

// File: hw/rtl/gpd_back.sv
// Back end: expands bundles into result words behind an output register.
`timescale 1ns / 1ps

module gpd_back (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          q_valid,
  input  gpd_pkg::bundle_t              q_bundle,
  output logic                          q_pop,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [gpd_pkg::ROW_W-1:0]     out_center_row,
  output logic [gpd_pkg::COL_W-1:0]     out_center_col,
  output logic                          out_is_peak,
  output logic                          out_last_of_run
);

  import gpd_pkg::*;

  logic [2:0]       done_r, rem, sel;
  logic             last, load;
  logic             out_valid_r;
  logic [ROW_W-1:0] row_sel, out_row_r;
  logic [COL_W-1:0] col_sel, out_col_r;
  logic             peak_sel, out_peak_r, out_last_r;

  assign rem  = q_bundle.has & ~done_r;
  assign last = ((rem & ~sel) == '0);
  assign load = q_valid & (~out_valid_r | ~out_stall);
  assign q_pop = load & last;

  always_comb begin
    sel      = '0;
    row_sel  = q_bundle.row;
    col_sel  = q_bundle.col;
    peak_sel = q_bundle.peak[RES_CORNER];
    if (rem[RES_UP]) begin
      sel[RES_UP] = 1'b1;
      row_sel     = q_bundle.row - ROW_W'(1);
      peak_sel    = q_bundle.peak[RES_UP];
    end else if (rem[RES_LEFT]) begin
      sel[RES_LEFT] = 1'b1;
      col_sel       = q_bundle.col - COL_W'(1);
      peak_sel      = q_bundle.peak[RES_LEFT];
    end else begin
      sel[RES_CORNER] = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      done_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (load) begin
        done_r      <= last ? '0 : (done_r | sel);
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_row_r  <= row_sel;
      out_col_r  <= col_sel;
      out_peak_r <= peak_sel;
      out_last_r <= last;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_center_row  = out_row_r;
  assign out_center_col  = out_col_r;
  assign out_is_peak     = out_peak_r;
  assign out_last_of_run = out_last_r;

endmodule

// File: hw/rtl/grid_local_peak_detector_top.sv
// Top level of the grid local peak detector: register port and block wiring.
// A result word passes the front-end stage, bundle queue and output register in turn.
// Throughput: one sample per cycle unless stalled; last-row samples past column 0 make
//   2 or 3 words; input then follows output at one word per cycle via a 4-bundle queue.
// Reset clears position, queue and output control; dims return to 1024 x 1024.
// Row store contents are kept across reset and register writes.
`timescale 1ns / 1ps

module grid_local_peak_detector_top (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [gpd_pkg::CFG_ADDR_W-1:0]    paddr,
  input  logic [gpd_pkg::CFG_DATA_W-1:0]    pwdata,
  output logic [gpd_pkg::CFG_DATA_W-1:0]    prdata,
  output logic                              pready,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic signed [gpd_pkg::SAMPLE_WIDTH-1:0] in_pixel_value,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic [gpd_pkg::ROW_W-1:0]         out_center_row,
  output logic [gpd_pkg::COL_W-1:0]         out_center_col,
  output logic                              out_is_peak,
  output logic                              out_last_of_run
);

  import gpd_pkg::*;

  logic              wr_en;
  logic [CFG_W-1:0]  wv;
  logic [ROW_W-1:0]  rows_last_r, rows_last_nxt;
  logic [COL_W-1:0]  cols_last_r, cols_last_nxt;
  cfg_dims_t         dims;
  logic              q_push, q_pop, q_valid;
  bundle_t           push_bundle, head_bundle;
  logic [QLVL_W-1:0] q_level;

  assign pready = 1'b1;
  assign wr_en  = psel & penable & pwrite & pready;
  assign wv     = pwdata[CFG_W-1:0];

  always_comb begin
    rows_last_nxt = rows_last_r;
    cols_last_nxt = cols_last_r;
    if (wr_en && paddr[2] == REG_NUM_ROWS) begin
      if (wv < CFG_W'(2)) begin
        rows_last_nxt = ROW_W'(1);
      end else if (32'(wv) > MAX_ROWS) begin
        rows_last_nxt = ROW_W'(MAX_ROWS - 1);
      end else begin
        rows_last_nxt = ROW_W'(wv - CFG_W'(1));
      end
    end
    if (wr_en && paddr[2] == REG_NUM_COLS) begin
      if (wv < CFG_W'(2)) begin
        cols_last_nxt = COL_W'(1);
      end else if (32'(wv) > MAX_COLS) begin
        cols_last_nxt = COL_W'(MAX_COLS - 1);
      end else begin
        cols_last_nxt = COL_W'(wv - CFG_W'(1));
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rows_last_r <= ROW_W'(ROWS_RST_LAST);
      cols_last_r <= COL_W'(COLS_RST_LAST);
    end else begin
      rows_last_r <= rows_last_nxt;
      cols_last_r <= cols_last_nxt;
    end
  end

  always_comb begin
    if (paddr[2] == REG_NUM_ROWS) begin
      prdata = CFG_DATA_W'(rows_last_r) + CFG_DATA_W'(1);
    end else begin
      prdata = CFG_DATA_W'(cols_last_r) + CFG_DATA_W'(1);
    end
  end

  assign dims.rows_last = rows_last_r;
  assign dims.cols_last = cols_last_r;

  gpd_front u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .dims           (dims),
    .restart        (wr_en),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_pixel_value (in_pixel_value),
    .q_level        (q_level),
    .q_push         (q_push),
    .q_bundle       (push_bundle)
  );

  gpd_queue u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (q_push),
    .din     (push_bundle),
    .pop     (q_pop),
    .dout    (head_bundle),
    .q_valid (q_valid),
    .level   (q_level)
  );

  gpd_back u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .q_valid         (q_valid),
    .q_bundle        (head_bundle),
    .q_pop           (q_pop),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_center_row  (out_center_row),
    .out_center_col  (out_center_col),
    .out_is_peak     (out_is_peak),
    .out_last_of_run (out_last_of_run)
  );

`ifndef SYNTHESIS
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    q_push && !q_pop |-> q_level < QLVL_W'(QDEPTH))
    else $error("bundle queue overflow");

  a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> q_valid)
    else $error("pop from empty bundle queue");

  a_run_continues: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_stall && !out_last_of_run |=> out_valid)
    else $error("result run broken before its last word");
`endif

endmodule

// File: bench/tb_top.sv
// Self-checking grid local peak detector testbench: directed, random, backpressure, largest grids.
`timescale 1ns / 1ps

module tb_top;
  import gpd_pkg::*;

  localparam int QUIET_LIMIT = 5000;
  localparam int DRAIN_CYCLES = 8;
  localparam logic [CFG_ADDR_W-1:0] ADDR_NUM_ROWS = {REG_NUM_ROWS, 2'b00};
  localparam logic [CFG_ADDR_W-1:0] ADDR_NUM_COLS = {REG_NUM_COLS, 2'b00};

  typedef struct packed {
    logic [ROW_W-1:0] row;
    logic [COL_W-1:0] col;
    logic             peak;
    logic             last;
  } decision_t;

  logic                  clk;
  logic                  rst_n;
  logic                  psel;
  logic                  penable;
  logic                  pwrite;
  logic [CFG_ADDR_W-1:0] paddr;
  logic [CFG_DATA_W-1:0] pwdata;
  logic [CFG_DATA_W-1:0] prdata;
  logic                  pready;
  logic                  in_valid;
  logic                  in_stall;
  sample_t               in_pixel_value;
  logic                  out_valid;
  logic                  out_stall;
  logic [ROW_W-1:0]      out_center_row;
  logic [COL_W-1:0]      out_center_col;
  logic                  out_is_peak;
  logic                  out_last_of_run;

  // predictor state
  sample_t   older_row [MAX_COLS];
  sample_t   newer_row [MAX_COLS];
  sample_t   prev_sample;
  int        cur_row;
  int        cur_col;
  int        grid_rows;
  int        grid_cols;
  decision_t pending_decisions[$];
  decision_t want;

  int errors;
  int quiet_cycles;
  int sender_idle_pct;
  int receiver_stall_pct;
  int hold_left;

  grid_local_peak_detector_top i_dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .psel            (psel),
    .penable         (penable),
    .pwrite          (pwrite),
    .paddr           (paddr),
    .pwdata          (pwdata),
    .prdata          (prdata),
    .pready          (pready),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_pixel_value  (in_pixel_value),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_center_row  (out_center_row),
    .out_center_col  (out_center_col),
    .out_is_peak     (out_is_peak),
    .out_last_of_run (out_last_of_run)
  );

  always begin
    clk = 1'b0;
    #10;
    clk = 1'b1;
    #10;
  end

  function automatic decision_t make_decision(input int r, input int c, input logic ok);
    decision_t d;
    d.row  = ROW_W'(r);
    d.col  = COL_W'(c);
    d.peak = ok;
    d.last = 1'b0;
    return d;
  endfunction

  function automatic int clamp_dim(input logic [CFG_DATA_W-1:0] data, input int maxv);
    int v;
    v = int'(data[CFG_W-1:0]);
    if (v < 2) v = 2;
    if (v > maxv) v = maxv;
    return v;
  endfunction

  // Works out the decisions caused by one accepted sample.
  task automatic predict_decisions(input sample_t x);
    int        r;
    int        c;
    sample_t   up_old;
    sample_t   center;
    sample_t   right;
    sample_t   cen;
    logic      ok;
    decision_t batch[$];
    r = cur_row;
    c = cur_col;
    if (r >= grid_rows || c >= grid_cols) begin
      r = 0;
      c = 0;
    end
    up_old = older_row[c];
    center = newer_row[c];
    right = '0;
    if (c + 1 < grid_cols) right = newer_row[c + 1];
    older_row[c] = center;
    newer_row[c] = x;
    if (r >= 1) begin
      ok = (center >= x);
      if (r >= 2 && !(center >= up_old)) ok = 1'b0;
      if (c >= 1 && !(center >= older_row[c - 1])) ok = 1'b0;
      if (c + 1 < grid_cols && !(center >= right)) ok = 1'b0;
      batch.push_back(make_decision(r - 1, c, ok));
    end
    if (r == grid_rows - 1 && c >= 1) begin
      cen = prev_sample;
      ok = (cen >= x) && (cen >= older_row[c - 1]);
      if (c >= 2 && !(cen >= newer_row[c - 2])) ok = 1'b0;
      batch.push_back(make_decision(r, c - 1, ok));
    end
    if (r == grid_rows - 1 && c == grid_cols - 1) begin
      ok = (x >= newer_row[c - 1]) && (x >= older_row[c]);
      batch.push_back(make_decision(r, c, ok));
    end
    if (batch.size() > 0) batch[batch.size() - 1].last = 1'b1;
    foreach (batch[i]) pending_decisions.push_back(batch[i]);
    prev_sample = x;
    c++;
    if (c >= grid_cols) begin
      c = 0;
      r++;
      if (r >= grid_rows) r = 0;
    end
    cur_row = r;
    cur_col = c;
  endtask

  task automatic send_word(input sample_t v);
    @(negedge clk);
    while ($urandom_range(0, 99) < sender_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid       <= 1'b1;
    in_pixel_value <= v;
    do begin
      @(posedge clk);
    end while (in_stall);
    predict_decisions(v);
  endtask

  // Drops valid and lets the block drain before anything else happens.
  task automatic drain_block();
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_decisions.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic set_dimension(input logic [0:0] idx, input logic [CFG_DATA_W-1:0] data);
    drain_block();
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= (idx == REG_NUM_ROWS) ? ADDR_NUM_ROWS : ADDR_NUM_COLS;
    pwdata  <= data;
    @(negedge clk);
    penable <= 1'b1;
    do begin
      @(posedge clk);
    end while (!pready);
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    if (idx == REG_NUM_ROWS) grid_rows = clamp_dim(data, MAX_ROWS);
    else grid_cols = clamp_dim(data, MAX_COLS);
    cur_row = 0;
    cur_col = 0;
  endtask

  function automatic sample_t pick_sample(input int mode);
    case (mode)
      0: return sample_t'($urandom());
      1: return sample_t'($urandom_range(0, 4)) - sample_t'(2);
      default: begin
        case ($urandom_range(0, 3))
          0: return sample_t'(16'sh7fff);
          1: return sample_t'(16'sh8000);
          2: return sample_t'(0);
          default: return sample_t'($urandom());
        endcase
      end
    endcase
  endfunction

  task automatic test_directed();
    sample_t seq[$];
    set_dimension(REG_NUM_ROWS, 32'd2);
    set_dimension(REG_NUM_COLS, 32'd2);
    seq = '{16'sh7fff, 16'sh8000, 16'sh8000, 16'sh7fff};
    foreach (seq[i]) send_word(seq[i]);
    // 3x3 with plateaus and ties
    set_dimension(REG_NUM_ROWS, 32'd3);
    set_dimension(REG_NUM_COLS, 32'd3);
    seq = '{16'sd7, 16'sd7, -16'sd3, 16'sd7, 16'sd2, 16'sd2, -16'sd1, 16'sd2, 16'sd9};
    foreach (seq[i]) send_word(seq[i]);
    // below-minimum values clamp to 2, upper data bits ignored
    set_dimension(REG_NUM_ROWS, 32'd1);
    set_dimension(REG_NUM_COLS, 32'hffff_f800);
    seq = '{-16'sd1, 16'sd0, 16'sd0, -16'sd1};
    foreach (seq[i]) send_word(seq[i]);
    // grid cut short, next write restarts it
    set_dimension(REG_NUM_ROWS, 32'd3);
    set_dimension(REG_NUM_COLS, 32'd3);
    seq = '{16'sd5, -16'sd5, 16'sd5, 16'sd5};
    foreach (seq[i]) send_word(seq[i]);
  endtask

  task automatic test_random_grids(input int item_goal);
    int sent;
    int rows;
    int cols;
    int cells;
    int mode;
    sent = 0;
    while (sent < item_goal) begin
      rows = $urandom_range(2, 6);
      cols = $urandom_range(2, 9);
      if ($urandom_range(0, 3) != 0 || sent == 0) begin
        if ($urandom_range(0, 1) == 1) begin
          set_dimension(REG_NUM_ROWS, {21'($urandom() >> 11), 11'(rows)});
          set_dimension(REG_NUM_COLS, {21'($urandom() >> 11), 11'(cols)});
        end else begin
          set_dimension(REG_NUM_COLS, {21'($urandom() >> 11), 11'(cols)});
          set_dimension(REG_NUM_ROWS, {21'($urandom() >> 11), 11'(rows)});
        end
      end
      cells = grid_rows * grid_cols * $urandom_range(1, 3);
      if ($urandom_range(0, 4) == 0) cells = $urandom_range(1, cells - 1);
      mode = $urandom_range(0, 2);
      repeat (cells) send_word(pick_sample(mode));
      sent += cells;
    end
  endtask

  task automatic test_backpressure();
    set_dimension(REG_NUM_ROWS, 32'd3);
    set_dimension(REG_NUM_COLS, 32'd8);
    hold_left = 300;
    repeat (48) send_word(pick_sample(1));
  endtask

  task automatic test_largest_grids();
    // above-maximum column count clamps to the maximum
    set_dimension(REG_NUM_ROWS, 32'd2);
    set_dimension(REG_NUM_COLS, 32'h0000_07ff);
    repeat (24) send_word(pick_sample(1));
    // above-maximum row count clamps to the maximum
    set_dimension(REG_NUM_COLS, 32'd2);
    set_dimension(REG_NUM_ROWS, 32'h0000_07ff);
    repeat (24) send_word(pick_sample(1));
  endtask

  always @(negedge clk) begin
    if (hold_left > 0) begin
      out_stall <= 1'b1;
      hold_left = hold_left - 1;
    end else begin
      out_stall <= ($urandom_range(0, 99) < receiver_stall_pct);
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (pending_decisions.size() == 0) begin
        $error("unexpected word: row %0d col %0d", out_center_row, out_center_col);
        errors++;
      end else begin
        want = pending_decisions.pop_front();
        if (out_center_row !== want.row) begin
          $error("center_row: expected %0d, got %0d", want.row, out_center_row);
          errors++;
        end
        if (out_center_col !== want.col) begin
          $error("center_col: expected %0d, got %0d", want.col, out_center_col);
          errors++;
        end
        if (out_is_peak !== want.peak) begin
          $error("is_peak: expected %0d, got %0d", want.peak, out_is_peak);
          errors++;
        end
        if (out_last_of_run !== want.last) begin
          $error("last_of_run: expected %0d, got %0d", want.last, out_last_of_run);
          errors++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || (psel && penable))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  initial begin
    rst_n              = 1'b0;
    psel               = 1'b0;
    penable            = 1'b0;
    pwrite             = 1'b0;
    paddr              = '0;
    pwdata             = '0;
    in_valid           = 1'b0;
    in_pixel_value     = '0;
    out_stall          = 1'b0;
    errors             = 0;
    quiet_cycles       = 0;
    hold_left          = 0;
    sender_idle_pct    = 0;
    receiver_stall_pct = 0;
    prev_sample        = '0;
    cur_row            = 0;
    cur_col            = 0;
    grid_rows          = MAX_ROWS;
    grid_cols          = MAX_COLS;
    foreach (older_row[i]) older_row[i] = '0;
    foreach (newer_row[i]) newer_row[i] = '0;
    repeat (10) @(negedge clk);
    rst_n <= 1'b1;

    test_directed();

    sender_idle_pct    = 8;
    receiver_stall_pct = 67;
    test_random_grids(90);

    sender_idle_pct    = 67;
    receiver_stall_pct = 8;
    test_random_grids(90);
    test_backpressure();

    sender_idle_pct    = 0;
    receiver_stall_pct = 0;
    test_random_grids(90);
    test_largest_grids();

    drain_block();
    if (pending_decisions.size() != 0) begin
      $error("%0d expected words never arrived", pending_decisions.size());
      errors++;
    end
    if (errors == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

// File: filelist.f
hw/rtl/gpd_pkg.sv
hw/rtl/gpd_ram.sv
hw/rtl/gpd_front.sv
hw/rtl/gpd_queue.sv
hw/rtl/gpd_back.sv
hw/rtl/grid_local_peak_detector_top.sv
bench/tb_top.sv
